// ===== src/srr_pkg.sv =====
`timescale 1ns / 1ps

package srr_pkg;

  localparam int SEQ_W     = 32;
  localparam int CNT_W     = 16;
  localparam int WIN_W     = 6;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HDR_SEQ       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 8'd3;

  localparam logic [SEQ_W-1:0] FIRST_DATA_OFS = 32'd2;
  localparam logic [WIN_W-1:0] WINDOW_RESET   = 6'd16;
  localparam logic [CNT_W-1:0] TIMEOUT_RESET  = 16'd5;

  localparam logic [1:0] ACKS_DUP = 2'd3;
  localparam logic [1:0] ACKS_ONE = 2'd1;

  localparam logic ACTION_SEGMENT = 1'b0;
  localparam logic ACTION_TICK    = 1'b1;

  typedef struct packed {
    logic cap;
    logic eval;
    logic mark;
    logic walk_start;
    logic walk_adv;
  } srr_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic tick_fire;
    logic seq_zero;
    logic below;
    logic drop;
    logic at_base;
    logic in_win;
    logic walk_go;
  } srr_stat_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
  } srr_cfg_t;

endpackage

// ===== src/srr_in_if.sv =====
`timescale 1ns / 1ps

interface srr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] seq;
  logic        checksum_ok;

  modport source (output valid, output action, output seq, output checksum_ok, input ready);
  modport sink (input valid, input action, input seq, input checksum_ok, output ready);
endinterface

// ===== src/srr_out_if.sv =====
`timescale 1ns / 1ps

interface srr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ack_seq;
  logic        store_enable;
  logic [15:0] store_index;
  logic        done_res;
  logic        last;

  modport source (output valid, output ack_seq, output store_enable, output store_index,
                  output done_res, output last, input ready);
  modport sink (input valid, input ack_seq, input store_enable, input store_index,
                input done_res, input last, output ready);
endinterface

// ===== src/srr_cfg_if.sv =====
`timescale 1ns / 1ps

interface srr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/srr_datapath.sv =====
`timescale 1ns / 1ps

module srr_datapath import srr_pkg::*; #(
  parameter int MaxWindow = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  srr_cmd_t         cmd_i,
  output srr_stat_t        stat_o,
  input  srr_cfg_t         cfg_i,
  input  logic             action_i,
  input  logic [SEQ_W-1:0] seq_i,
  input  logic             checksum_ok_i,
  output logic [SEQ_W-1:0] ack_seq_o,
  output logic             store_enable_o,
  output logic [CNT_W-1:0] store_index_o,
  output logic             done_res_o
);

  localparam int SlotW = $clog2(MaxWindow);
  localparam int WinW  = $clog2(MaxWindow + 1);
  localparam int EffW  = (WinW > WIN_W) ? WinW : WIN_W;
  localparam logic [EffW-1:0]  MaxWinE    = EffW'(MaxWindow);
  localparam logic [SlotW:0]   MaxWinS    = (SlotW + 1)'(MaxWindow);
  localparam logic [SlotW-1:0] LastSlot   = SlotW'(MaxWindow - 1);

  logic [SEQ_W-1:0]     hdr_q, base_q;
  logic [CNT_W-1:0]     seg_cnt_q, timeout_q, idle_q, base_off_q;
  logic [WIN_W-1:0]     win_q;
  logic [SlotW-1:0]     base_slot_q;
  logic [MaxWindow-1:0] ring_q;
  logic [WinW-1:0]      step_q;

  logic                 act_q, ok_q;
  logic [SEQ_W-1:0]     seq_q, ack_q;
  logic [SlotW-1:0]     delta_q;
  logic [CNT_W-1:0]     off_q, idx_q;
  logic                 en_q;

  logic                 restart;
  logic [EffW-1:0]      win_e, eff_e;
  logic [WinW-1:0]      eff_win;
  logic [SEQ_W:0]       last_seq, win_end;
  logic [SEQ_W-1:0]     delta, off;
  logic [CNT_W-1:0]     idle_nx;
  logic [SlotW:0]       slot_sum, slot_w;
  logic [SlotW-1:0]     slot, base_slot_nx;

  assign restart = cfg_i.we && (cfg_i.idx == REG_HDR_SEQ);

  assign win_e   = EffW'(win_q);
  assign eff_e   = (win_q == '0) ? EffW'(1) : ((win_e > MaxWinE) ? MaxWinE : win_e);
  assign eff_win = eff_e[WinW-1:0];

  assign last_seq = {1'b0, hdr_q} + (SEQ_W + 1)'(seg_cnt_q) + (SEQ_W + 1)'(1);
  assign win_end  = {1'b0, base_q} + (SEQ_W + 1)'(eff_win);
  assign delta    = seq_q - base_q;
  assign off      = seq_q - hdr_q - FIRST_DATA_OFS;
  assign idle_nx  = (idle_q == '1) ? idle_q : idle_q + CNT_W'(1);

  assign slot_sum     = {1'b0, base_slot_q} + {1'b0, delta_q};
  assign slot_w       = (slot_sum >= MaxWinS) ? slot_sum - MaxWinS : slot_sum;
  assign slot         = slot_w[SlotW-1:0];
  assign base_slot_nx = (base_slot_q == LastSlot) ? '0 : base_slot_q + SlotW'(1);

  always_comb begin
    stat_o.is_tick   = (act_q == ACTION_TICK);
    stat_o.tick_fire = (idle_nx > timeout_q);
    stat_o.seq_zero  = (seq_q == '0);
    stat_o.below     = (seq_q < base_q);
    stat_o.drop      = !ok_q || ({1'b0, seq_q} > last_seq);
    stat_o.at_base   = (seq_q == base_q);
    stat_o.in_win    = ({1'b0, seq_q} < win_end);
    stat_o.walk_go   = (step_q < eff_win) && (base_off_q < seg_cnt_q) && ring_q[base_slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q       <= '0;
      seg_cnt_q   <= '0;
      win_q       <= WINDOW_RESET;
      timeout_q   <= TIMEOUT_RESET;
      base_q      <= FIRST_DATA_OFS;
      base_off_q  <= '0;
      base_slot_q <= '0;
      ring_q      <= '0;
      idle_q      <= '0;
      step_q      <= '0;
    end else begin
      if (cfg_i.we) begin
        case (cfg_i.idx)
          REG_HDR_SEQ:       hdr_q     <= cfg_i.data[SEQ_W-1:0];
          REG_SEGMENT_COUNT: seg_cnt_q <= cfg_i.data[CNT_W-1:0];
          REG_WINDOW_SIZE:   win_q     <= cfg_i.data[WIN_W-1:0];
          REG_TIMEOUT_TICKS: timeout_q <= cfg_i.data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (restart) begin
        base_q      <= cfg_i.data[SEQ_W-1:0] + FIRST_DATA_OFS;
        base_off_q  <= '0;
        base_slot_q <= '0;
        ring_q      <= '0;
        idle_q      <= '0;
      end else begin
        if (cmd_i.eval) begin
          idle_q <= (act_q == ACTION_TICK) ? idle_nx : '0;
        end
        if (cmd_i.mark) begin
          ring_q[slot] <= 1'b1;
        end
        if (cmd_i.walk_adv) begin
          ring_q[base_slot_q] <= 1'b0;
          base_q              <= base_q + SEQ_W'(1);
          base_off_q          <= base_off_q + CNT_W'(1);
          base_slot_q         <= base_slot_nx;
        end
      end
      if (cmd_i.walk_start) begin
        step_q <= '0;
      end else if (cmd_i.walk_adv) begin
        step_q <= step_q + WinW'(1);
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      act_q <= action_i;
      seq_q <= seq_i;
      ok_q  <= checksum_ok_i;
    end
    if (cmd_i.eval) begin
      delta_q <= delta[SlotW-1:0];
      off_q   <= off[CNT_W-1:0];
      ack_q   <= ((act_q == ACTION_TICK) || (seq_q == '0)) ? base_q - SEQ_W'(1) : seq_q;
      en_q    <= 1'b0;
      idx_q   <= '0;
    end
    if (cmd_i.mark) begin
      en_q  <= 1'b1;
      idx_q <= off_q;
    end
  end

  assign ack_seq_o      = ack_q;
  assign store_enable_o = en_q;
  assign store_index_o  = idx_q;
  assign done_res_o     = (base_off_q >= seg_cnt_q);

endmodule

// ===== src/srr_ctrl.sv =====
`timescale 1ns / 1ps

module srr_ctrl import srr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic      out_last_o,
  input  srr_stat_t stat_i,
  output srr_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MARK = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign out_last_o  = (cnt_q == ACKS_ONE);

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    cmd_o            = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (stat_i.is_tick) begin
          cnt_d   = ACKS_DUP;
          state_d = stat_i.tick_fire ? S_EMIT : S_IDLE;
        end else if (stat_i.seq_zero) begin
          cnt_d   = ACKS_DUP;
          state_d = S_EMIT;
        end else if (stat_i.below) begin
          cnt_d   = ACKS_ONE;
          state_d = S_EMIT;
        end else if (stat_i.drop) begin
          state_d = S_IDLE;
        end else if (stat_i.at_base || stat_i.in_win) begin
          cnt_d   = ACKS_ONE;
          state_d = S_MARK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (stat_i.at_base) begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_WALK;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_WALK: begin
        if (stat_i.walk_go) begin
          cmd_o.walk_adv = 1'b1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready_i) begin
          if (cnt_q == ACKS_ONE) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q - 2'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== src/selective_repeat_receiver.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload                                                  Handshake
// in_i     in   action, seq, checksum_ok                                 valid/ready
// out_o    out  ack_seq, store_enable, store_index, done_res, last        valid/ready
// cfg_i    in   index (register), data                                   valid/ready
//
// One item at a time: accept, decode, then mark a slot when the segment is stored.
// A segment at base walks the received slots, one per cycle, up to the window size.
// Results leave one per cycle while out_o is ready, from the output register; three for duplicate acks.
// Drop: decode. Acks: decode, emit. Store: decode, mark, emit. At base: mark, walk, emit.
// Reset and a header sequence write clear the received slots at once; cfg is always ready.
// A stalled output holds the block; no new item is taken until the last result goes.

module selective_repeat_receiver import srr_pkg::*; #(
  parameter int MaxWindow = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  srr_in_if.sink     in_i,
  srr_out_if.source  out_o,
  srr_cfg_if.sink    cfg_i
);

  srr_cmd_t  cmd;
  srr_stat_t stat;
  srr_cfg_t  cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr.we   = cfg_i.valid;
  assign cfg_wr.idx  = cfg_i.index;
  assign cfg_wr.data = cfg_i.data;

  srr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_last_o  (out_o.last),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  srr_datapath #(
    .MaxWindow (MaxWindow)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_i          (cfg_wr),
    .action_i       (in_i.action),
    .seq_i          (in_i.seq),
    .checksum_ok_i  (in_i.checksum_ok),
    .ack_seq_o      (out_o.ack_seq),
    .store_enable_o (out_o.store_enable),
    .store_index_o  (out_o.store_index),
    .done_res_o     (out_o.done_res)
  );

endmodule
